// ===== sv/pinned_lru_cache_byte_budget_macros.svh =====
// Assertion macros for the pinned LRU cache directory.
`ifndef PINNED_LRU_CACHE_BYTE_BUDGET_MACROS_SVH
`define PINNED_LRU_CACHE_BYTE_BUDGET_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/plcb_pkg.sv =====
// Shared types, codes and helper functions of the cache directory.
`default_nettype none
package plcb_pkg;

    localparam int PLCB_SLOTS = 64;
    localparam logic [15:0] PLCB_BUDGET_RST = 16'd256;
    localparam int PLCB_MIB_SHIFT = 20;

    localparam int F_USED  = 0;
    localparam int F_READY = 1;
    localparam int F_READ  = 2;
    localparam int F_VALID = 3;

    typedef enum logic [2:0] {
        M_RETAIN, M_RELEASE, M_LOOKUP, M_STORE, M_ACQUIRE, M_FINISH, M_CLEAR, M_NONE
    } t_mode;

    typedef enum logic [2:0] {
        ST_DONE, ST_HIT, ST_MISS, ST_BUSY, ST_NOTFOUND, ST_FULL
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_DEC, S_APPLY, S_PRUNE, S_PCHK, S_OUT
    } t_state;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  flags;
        logic [15:0] pins;
        logic [31:0] size;
        logic [47:0] stamp;
    } t_entry;

    typedef struct packed {
        logic   shift;
        t_entry wb;
    } t_ring_ctl;

    function automatic logic counted(input t_entry e);
        return e.flags[F_USED] && e.flags[F_READY] && e.flags[F_VALID];
    endfunction

    function automatic logic evictable(input t_entry e);
        return counted(e) && !e.flags[F_READ] && (e.pins == 16'd0);
    endfunction

endpackage
`default_nettype wire

// ===== sv/plcb_if.sv =====
// Request and response channel interfaces of the cache directory.
`default_nettype none
interface plcb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [63:0] entry_key;
    logic [31:0] data_bytes;
    logic        data_ok;

    modport source (output valid, mode, entry_key, data_bytes, data_ok, input ready);
    modport sink (input valid, mode, entry_key, data_bytes, data_ok, output ready);
endinterface

interface plcb_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        hit_data_valid;
    logic [6:0]  evicted_count;
    logic [37:0] ready_total;

    modport source (output valid, status, hit_data_valid, evicted_count, ready_total,
                    input ready);
    modport sink (input valid, status, hit_data_valid, evicted_count, ready_total,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/pinned_lru_cache_byte_budget.sv =====
// Top level of the pinned LRU cache directory with a ready-byte budget.
// The directory entries live in a ring of SLOTS cells that rotates one place per
// cycle during a pass, so the sequencer at the head sees every entry once per
// pass and may rewrite it on its way round. An item is accepted, then goes
// through a search pass, a decision step, an update pass when an entry or the
// table changes, and an output step; a store that writes an entry, finish_read
// and clear add one pruning pass before the output, plus one more such pass per
// evicted entry (a single pass under a zero budget), each pass ending in a check
// step. The next item is accepted while a result still waits on the response
// channel.
`default_nettype none
`include "pinned_lru_cache_byte_budget_macros.svh"
module pinned_lru_cache_byte_budget import plcb_pkg::*; #(
    parameter int SLOTS = PLCB_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    plcb_in_if.sink     i_req,
    plcb_out_if.source  o_rsp
);

    t_ring_ctl w_ctl;
    t_entry    w_cell [SLOTS];
    logic      w_req_acc;
    logic      w_plain_rsp;

    plcb_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_head     (w_cell[0]),
        .o_ctl      (w_ctl)
    );

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k == SLOTS - 1) begin : g_tail
            plcb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_ctl.shift),
                .i_ent   (w_ctl.wb),
                .o_ent   (w_cell[k])
            );
        end else begin : g_mid
            plcb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_ctl.shift),
                .i_ent   (w_cell[k+1]),
                .o_ent   (w_cell[k])
            );
        end
    end

    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_plain_rsp = o_rsp.valid && (o_rsp.status == ST_HIT || o_rsp.status == ST_MISS
                         || o_rsp.status == ST_BUSY || o_rsp.status == ST_FULL);

    `PLCB_ASSERT_NOW(a_idle_no_shift, i_req.ready, !w_ctl.shift, "ring moved while idle")
    `PLCB_ASSERT_NEXT(a_accept_starts, w_req_acc, w_ctl.shift, "no search after accept")
    `PLCB_ASSERT_NOW(a_no_evict_on_access, w_plain_rsp, o_rsp.evicted_count == 7'd0, "eviction without pruning")

endmodule
`default_nettype wire

// ===== sv/plcb_cell.sv =====
// One directory entry of the rotating ring of cells.
`default_nettype none
module plcb_cell import plcb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_ent,
    output t_entry o_ent
);

    logic [63:0] r_key;
    logic [3:0]  r_flags;
    logic [15:0] r_pins;
    logic [31:0] r_size;
    logic [47:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_pins  <= '0;
        end else if (i_shift) begin
            r_flags <= i_ent.flags;
            r_pins  <= i_ent.pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_ent.key;
            r_size  <= i_ent.size;
            r_stamp <= i_ent.stamp;
        end
    end

    assign o_ent = '{key: r_key, flags: r_flags, pins: r_pins, size: r_size, stamp: r_stamp};

endmodule
`default_nettype wire

// ===== sv/plcb_ctrl.sv =====
// Sequencer at the head of the ring: search, update and pruning passes.
`default_nettype none
module plcb_ctrl import plcb_pkg::*; #(
    parameter int SLOTS = PLCB_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    plcb_in_if.sink     i_req,
    plcb_out_if.source  o_rsp,
    input  t_entry      i_head,
    output t_ring_ctl   o_ctl
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx;
    logic [15:0]   r_budget;
    t_mode         r_mode;
    logic [63:0]   r_key;
    logic [31:0]   r_bytes;
    logic          r_ok;
    logic          r_hit, r_free_vld, r_tgt_vld, r_prune, r_zero, r_hitv;
    logic [IW-1:0] r_hidx, r_fidx, r_tgt_idx;
    t_entry        r_hent, r_new;
    logic [38:0]   r_sum;
    logic [47:0]   r_clock;
    t_status       r_status;
    logic [6:0]    r_n;
    logic          r_vic_vld, r_best_vld;
    logic [IW-1:0] r_vic_idx, r_best_idx;
    logic [47:0]   r_best_stamp;
    logic [31:0]   r_best_size;
    logic          r_o_vld, r_o_hitv;
    t_status       r_o_status;
    logic [6:0]    r_o_n;
    logic [37:0]   r_o_total;

    t_entry        d_base, d_fill, d_new;
    logic          d_exists, d_tgt, d_tick, d_prune, d_hitv;
    logic [IW-1:0] d_idx;
    logic [47:0]   d_clk1;
    logic [31:0]   d_sub;
    logic [38:0]   d_sum, w_budget;
    t_status       d_status;
    logic          w_last, w_is_vic, w_over;

    assign w_budget = 39'({r_budget, {PLCB_MIB_SHIFT{1'b0}}});
    assign w_over   = r_sum > w_budget;
    assign w_last   = r_idx == LAST;
    assign w_is_vic = r_vic_vld && (r_idx == r_vic_idx);

    // Decision for the addressed entry, from what the search pass found.
    always_comb begin
        d_base           = r_hent;
        if (!r_hit) begin
            d_base       = '0;
            d_base.key   = r_key;
            d_base.flags[F_USED] = 1'b1;
        end
        d_exists = r_hit || r_free_vld;
        d_idx    = r_hit ? r_hidx : r_fidx;
        d_clk1   = r_clock + 48'd1;
        d_sub    = (r_hit && counted(r_hent)) ? r_hent.size : 32'd0;
        d_fill               = d_base;
        d_fill.flags[F_READY] = 1'b1;
        d_fill.flags[F_VALID] = 1'b1;
        d_fill.flags[F_READ]  = 1'b0;
        d_fill.size          = r_bytes;
        d_fill.stamp         = d_clk1;
        d_new    = d_base;
        d_tgt    = 1'b0;
        d_tick   = 1'b0;
        d_prune  = 1'b0;
        d_hitv   = 1'b0;
        d_status = ST_DONE;
        d_sum    = r_sum;
        case (r_mode)
            M_RETAIN: begin
                if (!d_exists) begin
                    d_status = ST_FULL;
                end else begin
                    d_tgt = 1'b1;
                    if (d_base.pins != 16'hFFFF) d_new.pins = d_base.pins + 16'd1;
                end
            end
            M_RELEASE: begin
                if (!r_hit) begin
                    d_status = ST_NOTFOUND;
                end else begin
                    d_tgt = 1'b1;
                    if (r_hent.pins != 16'd0) d_new.pins = r_hent.pins - 16'd1;
                end
            end
            M_LOOKUP: begin
                if (r_hit && r_hent.flags[F_READY]) begin
                    d_status = ST_HIT;
                    d_hitv   = r_hent.flags[F_VALID];
                end else begin
                    d_status = ST_NOTFOUND;
                end
            end
            M_STORE: begin
                if (r_ok) begin
                    if (!d_exists) begin
                        d_status = ST_FULL;
                    end else begin
                        d_tgt   = 1'b1;
                        d_tick  = 1'b1;
                        d_prune = 1'b1;
                        d_new   = d_fill;
                        d_sum   = r_sum - 39'(d_sub) + 39'(r_bytes);
                    end
                end
            end
            M_ACQUIRE: begin
                if (!r_hit) begin
                    if (!r_free_vld) begin
                        d_status = ST_FULL;
                    end else begin
                        d_tgt  = 1'b1;
                        d_tick = 1'b1;
                        d_new.flags[F_READ] = 1'b1;
                        d_new.stamp = d_clk1;
                        d_status = ST_MISS;
                    end
                end else if (r_hent.flags[F_READY]) begin
                    d_tgt  = 1'b1;
                    d_tick = 1'b1;
                    d_new.stamp = d_clk1;
                    d_status = ST_HIT;
                    d_hitv   = r_hent.flags[F_VALID];
                end else if (!r_hent.flags[F_READ]) begin
                    d_tgt  = 1'b1;
                    d_tick = 1'b1;
                    d_new.flags[F_READ] = 1'b1;
                    d_new.stamp = d_clk1;
                    d_status = ST_MISS;
                end else begin
                    d_status = ST_BUSY;
                end
            end
            M_FINISH: begin
                d_prune = 1'b1;
                if (!r_hit) begin
                    d_status = ST_NOTFOUND;
                end else begin
                    d_tgt = 1'b1;
                    if (r_ok) begin
                        d_tick = 1'b1;
                        d_new  = d_fill;
                        d_sum  = r_sum - 39'(d_sub) + 39'(r_bytes);
                    end else if (r_hent.pins != 16'd0) begin
                        // A failed read on a pinned entry leaves it ready without data.
                        d_tick = 1'b1;
                        d_new.flags[F_READY] = 1'b1;
                        d_new.flags[F_READ]  = 1'b0;
                        d_new.flags[F_VALID] = 1'b0;
                        d_new.size  = 32'd0;
                        d_new.stamp = d_clk1;
                        d_sum = r_sum - 39'(d_sub);
                    end else begin
                        d_new.flags = 4'd0;
                        d_new.pins  = 16'd0;
                        d_sum = r_sum - 39'(d_sub);
                    end
                end
            end
            M_CLEAR: d_prune = 1'b1;
            default: d_status = ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_ctl.shift = 1'b0;
        o_ctl.wb    = i_head;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_FIND;
            S_FIND: begin
                o_ctl.shift = 1'b1;
                if (w_last) n_state = S_DEC;
            end
            S_DEC: begin
                if (d_tgt || r_mode == M_CLEAR) n_state = S_APPLY;
                else if (d_prune)               n_state = S_PRUNE;
                else                            n_state = S_OUT;
            end
            S_APPLY: begin
                o_ctl.shift = 1'b1;
                if (r_tgt_vld && r_idx == r_tgt_idx) o_ctl.wb = r_new;
                if (r_mode == M_CLEAR && i_head.flags[F_USED] && !i_head.flags[F_READ]
                    && i_head.pins == 16'd0 && !counted(i_head)) begin
                    o_ctl.wb.flags = 4'd0;
                end
                if (w_last) n_state = r_prune ? S_PRUNE : S_OUT;
            end
            S_PRUNE: begin
                o_ctl.shift = 1'b1;
                if ((r_zero && evictable(i_head)) || (!r_zero && w_is_vic)) begin
                    o_ctl.wb.flags = 4'd0;
                    o_ctl.wb.pins  = 16'd0;
                end
                if (w_last) n_state = S_PCHK;
            end
            S_PCHK: begin
                if (!r_zero && w_over && r_best_vld) n_state = S_PRUNE;
                else                                 n_state = S_OUT;
            end
            S_OUT: if (!r_o_vld || o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_budget <= PLCB_BUDGET_RST;
            r_sum    <= '0;
            r_clock  <= '0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) r_budget <= i_cfg_data;
            if (o_ctl.shift) r_idx <= w_last ? '0 : r_idx + 1'b1;
            if (o_rsp.ready && r_state != S_OUT) r_o_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode     <= t_mode'(i_req.mode);
                        r_key      <= i_req.entry_key;
                        r_bytes    <= i_req.data_bytes;
                        r_ok       <= i_req.data_ok;
                        r_hit      <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_n        <= '0;
                        r_vic_vld  <= 1'b0;
                        r_best_vld <= 1'b0;
                        r_zero     <= r_budget == 16'd0;
                    end
                end
                S_FIND: begin
                    if (i_head.flags[F_USED] && i_head.key == r_key) begin
                        r_hit  <= 1'b1;
                        r_hidx <= r_idx;
                        r_hent <= i_head;
                    end
                    if (!i_head.flags[F_USED] && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_fidx     <= r_idx;
                    end
                end
                S_DEC: begin
                    r_tgt_vld <= d_tgt;
                    r_tgt_idx <= d_idx;
                    r_new     <= d_new;
                    r_status  <= d_status;
                    r_hitv    <= d_hitv;
                    r_prune   <= d_prune;
                    r_sum     <= d_sum;
                    if (d_tick) r_clock <= d_clk1;
                end
                S_APPLY: ;
                S_PRUNE: begin
                    if (r_zero) begin
                        if (evictable(i_head)) begin
                            r_sum <= r_sum - 39'(i_head.size);
                            if (r_n != 7'd127) r_n <= r_n + 7'd1;
                        end
                    end else if (!w_is_vic && evictable(i_head)
                                 && (!r_best_vld || i_head.stamp < r_best_stamp)) begin
                        // Strict compare keeps the lowest slot on equal stamps.
                        r_best_vld   <= 1'b1;
                        r_best_idx   <= r_idx;
                        r_best_stamp <= i_head.stamp;
                        r_best_size  <= i_head.size;
                    end
                end
                S_PCHK: begin
                    // The chosen victim is erased during the next pass.
                    if (!r_zero && w_over && r_best_vld) begin
                        r_vic_vld  <= 1'b1;
                        r_vic_idx  <= r_best_idx;
                        r_sum      <= r_sum - 39'(r_best_size);
                        r_best_vld <= 1'b0;
                        if (r_n != 7'd127) r_n <= r_n + 7'd1;
                    end else begin
                        r_vic_vld <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (!r_o_vld || o_rsp.ready) begin
                        r_o_vld    <= 1'b1;
                        r_o_status <= r_status;
                        r_o_hitv   <= r_hitv;
                        r_o_n      <= r_n;
                        r_o_total  <= r_sum[37:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_req.ready          = r_state == S_IDLE;
    assign o_rsp.valid          = r_o_vld;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.hit_data_valid = r_o_hitv;
    assign o_rsp.evicted_count  = r_o_n;
    assign o_rsp.ready_total    = r_o_total;

endmodule
`default_nettype wire
